@@ hw/rtl/ardt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ardt_pkg
// Shared types and codes for the abort retry delay table.
// ----------------------------------------------------------------------------
package ardt_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_PARKED   = 3'd0;
    localparam status_t ST_RELEASED = 3'd1;
    localparam status_t ST_FRESH    = 3'd2;
    localparam status_t ST_WAIT     = 3'd3;
    localparam status_t ST_FULL     = 3'd4;

    localparam logic CMD_PARK  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam int TIME_W = 64;
    localparam int QH_W   = 16;
    localparam int PEN_W  = 32;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PARK   = 5'b00010,
        S_FETCH  = 5'b00100,
        S_WCALC  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/abort_retry_delay_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abort_retry_delay_table
// Parks aborted query handles in a slot table until their retry time and
// hands them back on fetch; reports wait time when full and nothing is ready.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | cmd, query_handle, now, penalty
//  out     | out_valid / out_ready | status, out_handle, wait_time
//  cfg     | cfg_valid / cfg_ready | cfg_data (buffer_enable)
//
//  a word is taken only in idle; a park scans the valid bits one slot a cycle,
//  a fetch streams the slot memory through a registered
//  read port; a disabled word, a full park or a fetch on an empty table
//  goes straight to the result state.
//  reset clears the valid bits and sets the free count to SLOTS; slot contents are left.
//  the result sits in an output register, so a stalled out side holds only
//  the next result, not the next input word.
// ----------------------------------------------------------------------------
module abort_retry_delay_table #(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             cmd,
    input  wire logic [ardt_pkg::QH_W-1:0]        query_handle,
    input  wire logic [ardt_pkg::TIME_W-1:0]      now,
    input  wire logic [ardt_pkg::PEN_W-1:0]       penalty,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output ardt_pkg::status_t                     status,
    output logic [ardt_pkg::QH_W-1:0]             out_handle,
    output logic [ardt_pkg::TIME_W-1:0]           wait_time
);
    import ardt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = HANDLE_BITS + TIME_W;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // control state
    state_t                 state_reg, state_next;
    logic                   enable_reg, enable_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic [CNT_W-1:0]       free_reg, free_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic [QH_W-1:0]        handle_reg, handle_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [TIME_W-1:0]      ready_sum_reg, ready_sum_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [TIME_W-1:0]      min_reg, min_next;
    status_t                res_status_reg, res_status_next;
    logic [QH_W-1:0]        res_handle_reg, res_handle_next;
    logic [TIME_W-1:0]      res_wait_reg, res_wait_next;
    status_t                out_status_reg, out_status_next;
    logic [QH_W-1:0]        out_handle_reg, out_handle_next;
    logic [TIME_W-1:0]      out_wait_reg, out_wait_next;

    // slot memory: {handle, ready time}
    logic [ENT_W-1:0]       mem [SLOTS];
    logic [ENT_W-1:0]       rd_data_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENT_W-1:0]       mem_wdata;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;

    logic                   in_fire;
    logic [TIME_W:0]        sum_wide;
    logic [TIME_W-1:0]      rd_ready;
    logic [HANDLE_BITS-1:0] rd_handle;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign out_handle = out_handle_reg;
    assign wait_time  = out_wait_reg;

    assign sum_wide  = {1'b0, now} + {{(TIME_W + 1 - PEN_W){1'b0}}, penalty};
    assign rd_ready  = rd_data_reg[TIME_W-1:0];
    assign rd_handle = rd_data_reg[ENT_W-1:TIME_W];

    always_comb
    begin
        state_next      = state_reg;
        enable_next     = enable_reg;
        valid_next      = valid_reg;
        free_next       = free_reg;
        rd_cnt_next     = rd_cnt_reg;
        chk_vld_next    = 1'b0;
        out_valid_next  = out_valid_reg;
        handle_next     = handle_reg;
        now_next        = now_reg;
        ready_sum_next  = ready_sum_reg;
        idx_next        = idx_reg;
        min_next        = min_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_wait_next   = res_wait_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_wait_next   = out_wait_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = {HANDLE_BITS'(handle_reg), ready_sum_reg};
        mem_re          = 1'b0;
        mem_raddr       = rd_cnt_reg[IDX_W-1:0];

        if (cfg_valid && cfg_ready)
        begin
            enable_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    handle_next     = query_handle;
                    now_next        = now;
                    ready_sum_next  = sum_wide[TIME_W] ? {TIME_W{1'b1}}
                                                       : sum_wide[TIME_W-1:0];
                    res_handle_next = '0;
                    res_wait_next   = '0;
                    if (!enable_reg)
                    begin
                        // plain delay mode leaves the table alone
                        if (cmd == CMD_PARK)
                        begin
                            res_status_next = ST_WAIT;
                            res_wait_next   = TIME_W'(penalty);
                        end
                        else
                        begin
                            res_status_next = ST_FRESH;
                        end
                        state_next = S_RESULT;
                    end
                    else if (cmd == CMD_PARK)
                    begin
                        if (free_reg == '0)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_PARK;
                        end
                    end
                    else
                    begin
                        if (free_reg == SLOTS_C)
                        begin
                            res_status_next = ST_FRESH;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            rd_cnt_next = '0;
                            min_next    = {TIME_W{1'b1}};
                            state_next  = S_FETCH;
                        end
                    end
                end
            end

            S_PARK:
            begin
                // a free slot exists, so the scan stops at it
                if (!valid_reg[idx_reg])
                begin
                    mem_we             = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    free_next          = free_reg - CNT_W'(1);
                    res_status_next    = ST_PARKED;
                    state_next         = S_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_FETCH:
            begin
                // issue one read a cycle, check the word read last cycle
                if (rd_cnt_reg < SLOTS_C)
                begin
                    mem_re       = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    idx_next     = rd_cnt_reg[IDX_W-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (valid_reg[idx_reg] && (now_reg > rd_ready))
                    begin
                        valid_next[idx_reg] = 1'b0;
                        free_next           = free_reg + CNT_W'(1);
                        res_status_next     = ST_RELEASED;
                        res_handle_next     = QH_W'(rd_handle);
                        chk_vld_next        = 1'b0;
                        state_next          = S_RESULT;
                    end
                    else
                    begin
                        if ((free_reg == '0) && (rd_ready < min_reg))
                        begin
                            min_next = rd_ready;
                        end
                        if (idx_reg == LAST_IDX)
                        begin
                            chk_vld_next = 1'b0;
                            state_next   = S_WCALC;
                        end
                    end
                end
            end

            S_WCALC:
            begin
                if (free_reg == '0)
                begin
                    res_status_next = ST_WAIT;
                    res_wait_next   = (min_reg >= now_reg) ? (min_reg - now_reg) : '0;
                end
                else
                begin
                    res_status_next = ST_FRESH;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_wait_next   = res_wait_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b1;
            valid_reg     <= '0;
            free_reg      <= SLOTS_C;
            rd_cnt_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            valid_reg     <= valid_next;
            free_reg      <= free_next;
            rd_cnt_reg    <= rd_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg     <= handle_next;
        now_reg        <= now_next;
        ready_sum_reg  <= ready_sum_next;
        idx_reg        <= idx_next;
        min_reg        <= min_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_wait_reg   <= res_wait_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_wait_reg   <= out_wait_next;
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the abort retry delay table against a scoreboard that keeps its own
// copy of the slot table and enable bit, predicts every park and fetch result
// and compares each returned word field by field. Stimulus runs a directed
// part, then bursts of parks, fetches, drains and noise, under changing
// enable settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import ardt_pkg::*;

    localparam int          TABLE_SLOTS     = 16;
    localparam int unsigned RUN_LIMIT       = 500000;
    localparam int unsigned PRESSURE_AT     = 500;
    localparam int unsigned PRESSURE_CYCLES = 400;

    typedef struct {
        logic              op;
        logic [QH_W-1:0]   qh;
        logic [TIME_W-1:0] t_now;
        logic [PEN_W-1:0]  pen;
    } word_t;

    typedef struct {
        status_t           status;
        logic [QH_W-1:0]   handle;
        logic [TIME_W-1:0] wait_ns;
    } result_t;

    class retry_table_book;
        bit                enabled;
        bit                occupied [TABLE_SLOTS];
        logic [QH_W-1:0]   held_qh  [TABLE_SLOTS];
        logic [TIME_W-1:0] due_ns   [TABLE_SLOTS];
        int unsigned       vacant;
        result_t           expected_q [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            enabled      = 1'b1;
            vacant       = TABLE_SLOTS;
            mismatches   = 0;
            results_seen = 0;
            foreach (occupied[i])
            begin
                occupied[i] = 1'b0;
            end
        endfunction

        function void set_enable(logic v);
            enabled = v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function void note_word(logic op, logic [QH_W-1:0] qh, logic [TIME_W-1:0] t_now,
                                logic [PEN_W-1:0] pen);
            result_t           r;
            logic [TIME_W:0]   total;
            logic [TIME_W-1:0] earliest;
            int                hit;
            r.status  = ST_FRESH;
            r.handle  = '0;
            r.wait_ns = '0;
            hit       = -1;
            if (!enabled)
            begin
                if (op == CMD_PARK)
                begin
                    r.status  = ST_WAIT;
                    r.wait_ns = {{(TIME_W - PEN_W){1'b0}}, pen};
                end
            end
            else if (op == CMD_PARK)
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (hit < 0 && !occupied[i])
                        hit = i;
                end
                if (hit < 0)
                    r.status = ST_FULL;
                else
                begin
                    // ready time saturates instead of wrapping
                    total = {1'b0, t_now} + {{(TIME_W + 1 - PEN_W){1'b0}}, pen};
                    occupied[hit] = 1'b1;
                    held_qh[hit]  = qh;
                    due_ns[hit]   = total[TIME_W] ? '1 : total[TIME_W-1:0];
                    vacant--;
                    r.status = ST_PARKED;
                end
            end
            else
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (hit < 0 && occupied[i] && t_now > due_ns[i])
                        hit = i;
                end
                if (hit >= 0)
                begin
                    occupied[hit] = 1'b0;
                    vacant++;
                    r.status = ST_RELEASED;
                    r.handle = held_qh[hit];
                end
                else if (vacant == 0)
                begin
                    earliest = '1;
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (due_ns[i] < earliest)
                            earliest = due_ns[i];
                    end
                    r.status  = ST_WAIT;
                    r.wait_ns = (earliest >= t_now) ? earliest - t_now : '0;
                end
            end
            expected_q.push_back(r);
        endfunction

        task check_result(status_t st, logic [QH_W-1:0] qh, logic [TIME_W-1:0] w);
            result_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word status %0d handle %h wait %h",
                                        st, qh, w));
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status || qh !== e.handle || w !== e.wait_ns)
                flag_mismatch($sformatf(
                    "word %0d got status %0d handle %h wait %h, want %0d %h %h",
                    results_seen, st, qh, w, e.status, e.handle, e.wait_ns));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              cmd;
    logic [QH_W-1:0]   query_handle;
    logic [TIME_W-1:0] now;
    logic [PEN_W-1:0]  penalty;
    logic              out_valid;
    logic              out_ready;
    status_t           status;
    logic [QH_W-1:0]   out_handle;
    logic [TIME_W-1:0] wait_time;

    retry_table_book   book;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    logic [TIME_W-1:0] clock_ns;

    abort_retry_delay_table #(
        .SLOTS       (TABLE_SLOTS),
        .HANDLE_BITS (QH_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .query_handle (query_handle),
        .now          (now),
        .penalty      (penalty),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_handle   (out_handle),
        .wait_time    (wait_time)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // results are checked before the word taken at the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                book.check_result(status, out_handle, wait_time);
            if (in_valid && in_ready)
                book.note_word(cmd, query_handle, now, penalty);
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial
    begin : receiver
        int unsigned hold_left;
        bit          hold_armed;
        hold_left  = 0;
        hold_armed = 1'b1;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (hold_armed && book != null && book.results_seen >= PRESSURE_AT)
            begin
                hold_armed = 1'b0;
                hold_left  = PRESSURE_CYCLES - 1;
                out_ready  = 1'b0;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic word_t mk_word(logic op, logic [QH_W-1:0] qh, logic [TIME_W-1:0] t_now,
                                      logic [PEN_W-1:0] pen);
        word_t w;
        w.op    = op;
        w.qh    = qh;
        w.t_now = t_now;
        w.pen   = pen;
        return w;
    endfunction

    task automatic send_word(input word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        cmd          = w.op;
        query_handle = w.qh;
        now          = w.t_now;
        penalty      = w.pen;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_enable(input logic v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.set_enable(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int unsigned n_words);
        int unsigned sent;
        int unsigned kind;
        int unsigned burst;
        word_t       w;
        sent = 0;
        while (sent < n_words)
        begin
            kind  = $urandom_range(0, 19);
            burst = (kind < 8)  ? $urandom_range(1, 20) :
                    (kind < 16) ? $urandom_range(1, 12) :
                    (kind < 18) ? 1 : $urandom_range(4, 18);
            repeat (burst)
            begin
                w.qh  = QH_W'($urandom);
                w.pen = $urandom;
                if (kind < 8)
                begin
                    // parks at the running clock, mostly short penalties
                    w.op    = CMD_PARK;
                    w.t_now = clock_ns;
                    case ($urandom_range(0, 15))
                        0:       w.pen = '0;
                        1:       w.pen = $urandom;
                        default: w.pen = $urandom_range(1, 600);
                    endcase
                    clock_ns += $urandom_range(0, 20);
                end
                else if (kind < 16)
                begin
                    w.op    = CMD_FETCH;
                    w.t_now = clock_ns;
                    clock_ns += $urandom_range(0, 80);
                end
                else if (kind < 18)
                begin
                    w.op    = 1'($urandom_range(0, 1));
                    w.t_now = {$urandom, $urandom};
                end
                else
                begin
                    // drain: at a far-future clock each fetch frees any entry but saturated ones
                    w.op    = CMD_FETCH;
                    w.t_now = {32'hFFFF_FFFF, 32'($urandom)};
                end
                send_word(w);
                sent++;
            end
        end
    endtask

    initial
    begin
        book           = new();
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_PARK;
        query_handle   = '0;
        now            = '0;
        penalty        = '0;
        send_idle_pct  = 20;
        recv_stall_pct = 86;
        clock_ns       = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        write_enable(1'b1);
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'd100, 32'd0));
        send_word(mk_word(CMD_PARK, 16'hFFFF, 64'd1000, 32'd0));
        // ready exactly at now stays parked
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'd1000, 32'd0));
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'd1001, 32'd0));
        // saturating ready time; this entry can never be released
        send_word(mk_word(CMD_PARK, 16'h0000, 64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF));
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        for (int i = 1; i < TABLE_SLOTS; i++)
            send_word(mk_word(CMD_PARK, 16'(16'h1111 * i), 64'd2000, 32'(500 - 20 * i)));
        send_word(mk_word(CMD_PARK, 16'hA5A5, 64'd2000, 32'd5));
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'd2000, 32'd0));
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'd2200, 32'd0));
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'd2201, 32'd0));
        settle();

        write_enable(1'b0);
        send_word(mk_word(CMD_PARK, 16'h5A5A, 64'd3000, 32'hFFFF_FFFF));
        send_word(mk_word(CMD_FETCH, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        settle();
        write_enable(1'b1);

        clock_ns = 64'd5000 + $urandom_range(0, 1000);
        run_random(190);
        settle();
        write_enable(1'b0);
        run_random(25);
        settle();
        write_enable(1'b1);

        send_idle_pct  = 86;
        recv_stall_pct = 20;
        run_random(190);
        settle();
        write_enable(1'b0);
        run_random(15);
        settle();
        write_enable(1'b1);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(200);
        settle();
        repeat (TABLE_SLOTS + 8) @(negedge clk);

        if (book.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/ardt_pkg.sv
hw/rtl/abort_retry_delay_table.sv
bench/tb.sv
